[hdl/sws_pkg.sv]
// Shared types and constants for the sliding window median core.
// No dependencies; sws_cell, the core and sws_checker use it, sws_ram does not.
package sws_pkg;

  // Window and sample geometry
  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 33;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CFG_W      = 7;

  // Median gather tree: cells are ORed in groups, then across groups
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W:0]   sum_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  // Broadcast to every cell of the sorted row
  typedef struct packed {
    cell_op_e op;
    sample_t  key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_GATHER,
    ST_SUM
  } core_state_e;

endpackage

[hdl/sws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the arrival ring of the median core.
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sws_cell.sv]
// One cell of the sorted row: holds one window value and shifts it
// toward or away from its neighbors on remove and insert. Uses sws_pkg.
module sws_cell (
  input  logic                clk_i,
  input  sws_pkg::cell_ctrl_t ctrl_i,
  input  sws_pkg::sample_t    left_val_i,
  input  logic                left_gt_i,
  input  sws_pkg::sample_t    right_val_i,
  input  logic                in_win_i,
  output sws_pkg::sample_t    val_o,
  output logic                gt_o
);
  import sws_pkg::*;

  sample_t val_q, val_d;
  sample_t key;
  logic    ge;

  assign key = $signed(ctrl_i.key);

  // Compare against the broadcast key; cells past the window count as greater
  always_comb begin
    ge   = (val_q >= key);
    gt_o = !in_win_i || (val_q > key);
  end

  // Remove: the first cell not below the key and all above it pull from the right.
  // Insert: cells above the key take the left value, the boundary cell takes the key.
  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_REMOVE: begin
        if (ge) begin
          val_d = right_val_i;
        end
      end
      CELL_INSERT: begin
        if (gt_o) begin
          val_d = left_gt_i ? left_val_i : key;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[hdl/sliding_window_median_core.sv]
// Top level of the running median core: sequencer, sorted cell row,
// arrival ring and median gather. Uses sws_pkg, sws_cell and sws_ram.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid_i, in_ready_o, sample_i,     | in
//          | start_req_i                           |
//  output  | out_valid_o, out_ready_i,             | out
//          | median_doubled_o                      |
//  config  | cfg_valid_i, cfg_ready_o,             | in
//          | window_size_i                         |
//
// A sample that yields no result passes through accept, remove step and insert
// step; one that yields a result also passes through gather and sum, a path set
// by the ring read and the shared remove/insert pass over the cell row.
// Reset clears the control state at once; there is no clearing pass.
// A result held by a stalled output register blocks only the final sum step.
module sliding_window_median_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [sws_pkg::IN_W-1:0] sample_i,
  input  logic                            start_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [sws_pkg::OUT_W-1:0] median_doubled_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sws_pkg::CFG_W-1:0]       window_size_i
);
  import sws_pkg::*;

  core_state_e           state_q, state_d;
  logic [CFG_W-1:0]      ws_q, ws_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic                  full_q, full_d;
  logic                  emit_q, emit_d;
  logic [CNT_W-1:0]      lim_q, lim_d;
  sample_t               sample_q, sample_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] median_q, median_d;

  logic [CNT_W-1:0]      w_eff;
  logic [CNT_W-1:0]      lo_idx, hi_idx;
  logic                  restart;
  logic [CNT_W-1:0]      fill_eff;
  logic [PTR_W-1:0]      ptr_eff;
  logic [CNT_W-1:0]      ptr_inc;

  cell_ctrl_t            cell_ctrl;
  sample_t               cell_val [WINDOW_MAX];
  logic                  cell_gt  [WINDOW_MAX];
  logic                  cell_win [WINDOW_MAX];

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [SAMPLE_W-1:0]   ram_rdata;

  sample_t               grp_lo_d [NUM_GROUPS];
  sample_t               grp_hi_d [NUM_GROUPS];
  sample_t               grp_lo_q [NUM_GROUPS];
  sample_t               grp_hi_q [NUM_GROUPS];
  sample_t               mid_lo, mid_hi;
  sum_t                  mid_sum;

  // Clamp the window size to 1..WINDOW_MAX and locate the middle cells
  always_comb begin
    if (ws_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(ws_q) > CNT_W'(WINDOW_MAX)) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(ws_q);
    end
    lo_idx = (w_eff - CNT_W'(1)) >> 1;
    hi_idx = w_eff >> 1;
  end

  // Window bookkeeping as seen by an arriving sample
  always_comb begin
    restart  = start_req_i || (fill_q > w_eff);
    fill_eff = restart ? '0 : fill_q;
    ptr_eff  = (restart || (CNT_W'(ptr_q) >= w_eff)) ? '0 : ptr_q;
    ptr_inc  = CNT_W'(ptr_q) + CNT_W'(1);
  end

  // Arrival ring, read at the oldest slot while the sequencer idles
  sws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .raddr_i (ptr_eff),
    .rdata_o (ram_rdata)
  );

  // Sorted cell row
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    sample_t left_val, right_val;
    logic    left_gt;

    if (i == 0) begin : g_first
      assign left_val = cell_ctrl.key;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_body
      assign right_val = cell_val[i+1];
    end

    assign cell_win[i] = (CNT_W'(i) < lim_q);

    sws_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .in_win_i    (cell_win[i]),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Pick the two middle cells, first stage: OR within each group
  always_comb begin
    int idx;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_lo_d[g] = '0;
      grp_hi_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        idx = g * GROUP_SIZE + j;
        if (idx < WINDOW_MAX) begin
          if (CNT_W'(idx) == lo_idx) begin
            grp_lo_d[g] = grp_lo_d[g] | cell_val[idx];
          end
          if (CNT_W'(idx) == hi_idx) begin
            grp_hi_d[g] = grp_hi_d[g] | cell_val[idx];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_lo_q[g] <= grp_lo_d[g];
      grp_hi_q[g] <= grp_hi_d[g];
    end
  end

  // Second stage: OR across groups and add the middle pair
  always_comb begin
    mid_lo = '0;
    mid_hi = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mid_lo = mid_lo | grp_lo_q[g];
      mid_hi = mid_hi | grp_hi_q[g];
    end
    mid_sum = sum_t'(mid_lo) + sum_t'(mid_hi);
  end

  // Sequencer: next state, cell commands, ring write, handshakes
  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    full_d      = full_q;
    emit_d      = emit_q;
    lim_d       = lim_q;
    sample_d    = sample_q;
    median_d    = median_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.key = sample_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          // Take the new window size and empty the window
          ws_d   = window_size_i;
          fill_d = '0;
          ptr_d  = '0;
        end else if (in_valid_i) begin
          sample_d = sample_i[SAMPLE_W-1:0];
          fill_d   = fill_eff;
          ptr_d    = ptr_eff;
          full_d   = (fill_eff == w_eff);
          state_d  = ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        ram_we = 1'b1;
        if (full_q) begin
          // Drop the oldest sample from the row, overwrite its ring slot
          cell_ctrl.op  = CELL_REMOVE;
          cell_ctrl.key = ram_rdata;
          ram_waddr     = ptr_q;
          ptr_d         = (ptr_inc >= w_eff) ? '0 : ptr_inc[PTR_W-1:0];
          lim_d         = w_eff - CNT_W'(1);
          emit_d        = 1'b1;
        end else begin
          ram_waddr = fill_q[PTR_W-1:0];
          fill_d    = fill_q + CNT_W'(1);
          lim_d     = fill_q;
          emit_d    = ((fill_q + CNT_W'(1)) == w_eff);
        end
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        cell_ctrl.op = CELL_INSERT;
        state_d      = emit_q ? ST_GATHER : ST_IDLE;
      end
      ST_GATHER: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          median_d    = OUT_W'(mid_sum);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= CFG_W'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      emit_q      <= 1'b0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      full_q      <= full_d;
      emit_q      <= emit_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    median_q <= median_d;
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;

endmodule

[hdl/sws_checker.sv]
// Port-level checks for sliding_window_median_core, attached by bind.
// Uses sws_pkg for port widths.
module sws_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic signed [sws_pkg::IN_W-1:0]  sample_i,
  input logic                             start_req_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [sws_pkg::OUT_W-1:0] median_doubled_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [sws_pkg::CFG_W-1:0]        window_size_i
);

  logic in_beat, cfg_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign cfg_beat = cfg_valid_i && cfg_ready_o;

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("result changed while stalled");

  // A waiting sample or register beat keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o |=> $stable(sample_i) && $stable(start_req_i))
    and (cfg_valid_i && !cfg_ready_o |=> $stable(window_size_i)))
    else $error("payload changed while waiting");

  // One sample at a time: the input closes after each beat
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("input reopened right after a beat");

  // A register write and a sample never land together
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_beat |-> !in_beat)
    else $error("register write and sample accepted together");

  // A new result never appears sooner than the remove/insert/gather/sum path
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_beat, 1) && !$past(in_beat, 2)
                           && !$past(in_beat, 3) && !$past(in_beat, 4))
    else $error("result appeared too soon after a sample");

endmodule

bind sliding_window_median_core sws_checker u_sws_checker (.*);
